>>> sv/assert_macros.svh
// Assertion macros used by the idle/move crossfade ramp RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk_i, rstn_i, expr, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk_i, rstn_i, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/imcr_pkg.sv
// Shared types and constants for the idle/move crossfade ramp.
// Used by imcr_motion, imcr_ramp and the top level idle_move_crossfade_ramp.
package imcr_pkg;

    localparam int VEL_W    = 16;
    localparam int DT_W     = 16;
    localparam int THR_W    = 16;
    localparam int DELAY_W  = 24;
    localparam int WEIGHT_W = 17;
    localparam int SQ_W     = 32;
    localparam int STEP_W   = DT_W + WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;
    localparam logic [DELAY_W-1:0]  TIMER_MAX   = 24'hFFFFFF;

    // Configuration register indexes
    localparam logic [1:0] REG_SPEED_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_IDLE_DELAY      = 2'd1;
    localparam logic [1:0] REG_FADE_RATE       = 2'd2;

    // Per-tick result of the stillness and step stage
    typedef struct packed {
        logic                still;    // squared speed at or under squared threshold
        logic                instant;  // fade rate is zero: jump to goal
        logic [DT_W-1:0]     dt;
        logic [WEIGHT_W-1:0] step;     // saturated weight step
    } tick_t;

endpackage

>>> sv/imcr_motion.sv
// Input register and stillness/step stage of the crossfade ramp.
// Depends on imcr_pkg for widths and the tick_t struct.
module imcr_motion
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [imcr_pkg::VEL_W-1:0] vel_x,
    input  logic signed [imcr_pkg::VEL_W-1:0] vel_z,
    input  logic [imcr_pkg::DT_W-1:0]      delta_time,
    input  logic [imcr_pkg::THR_W-1:0]     speed_threshold,
    input  logic [imcr_pkg::WEIGHT_W-1:0]  fade_rate,
    output logic                           tick_valid,
    output imcr_pkg::tick_t                tick
);

    logic                              s1_valid_reg;
    logic signed [imcr_pkg::VEL_W-1:0] vel_x_reg;
    logic signed [imcr_pkg::VEL_W-1:0] vel_z_reg;
    logic [imcr_pkg::DT_W-1:0]         dt_reg;

    logic                              s2_valid_reg;
    imcr_pkg::tick_t                   tick_reg;
    imcr_pkg::tick_t                   tick_next;

    logic signed [imcr_pkg::SQ_W-1:0]  sq_x;
    logic signed [imcr_pkg::SQ_W-1:0]  sq_z;
    logic [imcr_pkg::SQ_W-1:0]         sq_sum;
    logic [imcr_pkg::SQ_W-1:0]         thr_sq;
    logic [imcr_pkg::STEP_W-1:0]       step_full;

    always_comb
    begin
        sq_x      = vel_x_reg * vel_x_reg;
        sq_z      = vel_z_reg * vel_z_reg;
        // each square is at most 2^30, so the sum fits unsigned
        sq_sum    = $unsigned(sq_x) + $unsigned(sq_z);
        thr_sq    = {{imcr_pkg::THR_W{1'b0}}, speed_threshold}
                  * {{imcr_pkg::THR_W{1'b0}}, speed_threshold};
        step_full = {{imcr_pkg::WEIGHT_W{1'b0}}, dt_reg}
                  * {{imcr_pkg::DT_W{1'b0}}, fade_rate};

        tick_next.still   = (sq_sum <= thr_sq);
        tick_next.instant = (fade_rate == '0);
        tick_next.dt      = dt_reg;
        if (step_full > imcr_pkg::STEP_W'(imcr_pkg::FULL_WEIGHT))
        begin
            tick_next.step = imcr_pkg::FULL_WEIGHT;
        end
        else
        begin
            tick_next.step = step_full[imcr_pkg::WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vel_x_reg <= vel_x;
            vel_z_reg <= vel_z;
            dt_reg    <= delta_time;
            tick_reg  <= tick_next;
        end
    end

    assign tick_valid = s2_valid_reg;
    assign tick       = tick_reg;

endmodule

>>> sv/imcr_ramp.sv
// Timer, idle target and weight ramp state of the crossfade ramp; also the result register.
// Depends on imcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imcr_ramp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    input  imcr_pkg::tick_t                 tick,
    input  logic [imcr_pkg::DELAY_W-1:0]    idle_delay,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [imcr_pkg::WEIGHT_W-1:0]   move_weight,
    output logic                            idle_target,
    output logic                            en
);

    logic                            out_valid_reg;
    logic [imcr_pkg::WEIGHT_W-1:0]   weight_reg;
    logic [imcr_pkg::WEIGHT_W-1:0]   weight_next;
    logic                            target_reg;
    logic                            target_next;
    logic [imcr_pkg::DELAY_W-1:0]    still_time_reg;
    logic [imcr_pkg::DELAY_W-1:0]    still_time_next;

    logic                            upd;
    logic [imcr_pkg::DELAY_W:0]      still_sum;
    logic [imcr_pkg::DELAY_W-1:0]    still_sat;
    logic [imcr_pkg::WEIGHT_W-1:0]   goal;
    logic [imcr_pkg::WEIGHT_W-1:0]   gap;
    logic [imcr_pkg::WEIGHT_W-1:0]   delta;

    assign en  = !out_valid_reg || out_ready;
    assign upd = en && tick_valid;

    always_comb
    begin
        still_sum = {1'b0, still_time_reg}
                  + {{(imcr_pkg::DELAY_W + 1 - imcr_pkg::DT_W){1'b0}}, tick.dt};
        still_sat = still_sum[imcr_pkg::DELAY_W] ? imcr_pkg::TIMER_MAX
                                                 : still_sum[imcr_pkg::DELAY_W-1:0];
        if (tick.still)
        begin
            still_time_next = still_sat;
            target_next     = target_reg || (still_sat >= idle_delay);
        end
        else
        begin
            still_time_next = '0;
            target_next     = 1'b0;
        end

        goal = target_next ? '0 : imcr_pkg::FULL_WEIGHT;
        // never step past the goal
        gap   = (goal > weight_reg) ? (goal - weight_reg) : (weight_reg - goal);
        delta = (tick.step < gap) ? tick.step : gap;
        if (tick.instant)
        begin
            weight_next = goal;
        end
        else if (goal > weight_reg)
        begin
            weight_next = weight_reg + delta;
        end
        else
        begin
            weight_next = weight_reg - delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            weight_reg     <= imcr_pkg::FULL_WEIGHT;
            target_reg     <= 1'b0;
            still_time_reg <= '0;
        end
        else
        begin
            if (en)
            begin
                out_valid_reg <= tick_valid;
            end
            if (upd)
            begin
                weight_reg     <= weight_next;
                target_reg     <= target_next;
                still_time_reg <= still_time_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign move_weight = weight_reg;
    assign idle_target = target_reg;

    `ASSERT_ALWAYS(a_weight_range, clk, rst_n, weight_reg <= imcr_pkg::FULL_WEIGHT, "weight above full scale")
    `ASSERT_IMPLIES(a_ramp_direction, clk, rst_n, upd, target_next ? (weight_next <= weight_reg) : (weight_next >= weight_reg), "weight moved away from its goal")
    `ASSERT_NEXT(a_instant_jump, clk, rst_n, upd && tick.instant, weight_reg == (target_reg ? '0 : imcr_pkg::FULL_WEIGHT), "zero fade rate did not reach the goal")
    `ASSERT_NEXT(a_motion_clears, clk, rst_n, upd && !tick.still, still_time_reg == '0 && !target_reg, "motion left timer or idle target set")

endmodule

>>> sv/idle_move_crossfade_ramp.sv
// Idle/move crossfade ramp: holds the configuration registers and joins the two stages.
// Depends on imcr_pkg, imcr_motion and imcr_ramp.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one tick per item: signed velocity
//   components and elapsed time. Master stream (m_tvalid/m_tready/m_tdata) returns one
//   result per tick: the Q16 move weight and the idle target flag, in tick order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no item is in
//   flight: index 0 speed threshold, 1 idle delay, 2 fade rate; other indexes are ignored.
// Timing:
//   Throughput is one item per cycle while the output is not stalled: the item is
//   registered on input, the stillness compare and saturated step are registered next,
//   and the timer and weight update closes the loop in the state registers that drive
//   m_tdata.
// Reset:
//   Weight is 65536 (fully moving), idle target, timer and all configuration are cleared,
//   and the pipeline is empty.
// Stall:
//   While m_tvalid is high and m_tready low the whole pipeline holds and s_tready drops;
//   a held result keeps its value until taken.
module idle_move_crossfade_ramp
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vel_x[15:0], vel_z[31:16], delta_time[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // move_weight[16:0], idle_target[17], zero[23:18]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [imcr_pkg::THR_W-1:0]    speed_threshold_reg;
    logic [imcr_pkg::DELAY_W-1:0]  idle_delay_reg;
    logic [imcr_pkg::WEIGHT_W-1:0] fade_rate_reg;

    logic                          en;
    logic                          tick_valid;
    imcr_pkg::tick_t               tick;
    logic [imcr_pkg::WEIGHT_W-1:0] move_weight;
    logic                          idle_target;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_threshold_reg <= '0;
            idle_delay_reg      <= '0;
            fade_rate_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imcr_pkg::REG_SPEED_THRESHOLD: speed_threshold_reg <= cfg_data[imcr_pkg::THR_W-1:0];
                imcr_pkg::REG_IDLE_DELAY:      idle_delay_reg      <= cfg_data[imcr_pkg::DELAY_W-1:0];
                imcr_pkg::REG_FADE_RATE:       fade_rate_reg       <= cfg_data[imcr_pkg::WEIGHT_W-1:0];
                default:                       ;
            endcase
        end
    end

    assign s_tready = en;

    imcr_motion u_motion
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .vel_x           ($signed(s_tdata[15:0])),
        .vel_z           ($signed(s_tdata[31:16])),
        .delta_time      (s_tdata[47:32]),
        .speed_threshold (speed_threshold_reg),
        .fade_rate       (fade_rate_reg),
        .tick_valid      (tick_valid),
        .tick            (tick)
    );

    imcr_ramp u_ramp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick        (tick),
        .idle_delay  (idle_delay_reg),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .move_weight (move_weight),
        .idle_target (idle_target),
        .en          (en)
    );

    assign m_tdata = {6'b0, idle_target, move_weight};

endmodule

>>> dv/imcr_blend_monitor.sv
// Monitor for the idle/move crossfade ramp: follows the config port and both item streams,
// predicts each blend result and compares it with what the block returns.
// Depends on imcr_pkg for widths, register indexes and constants.
module imcr_blend_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // vel_x[15:0], vel_z[31:16], delta_time[47:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // move_weight[16:0], idle_target[17], zero[23:18]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          fails,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [imcr_pkg::WEIGHT_W-1:0] weight;
        logic                          idle;
    } blend_t;

    // Predictor copy of configuration and state
    logic [imcr_pkg::THR_W-1:0]    thr_q    = '0;
    logic [imcr_pkg::DELAY_W-1:0]  delay_q  = '0;
    logic [imcr_pkg::WEIGHT_W-1:0] rate_q   = '0;
    logic [imcr_pkg::WEIGHT_W-1:0] weight_q = imcr_pkg::FULL_WEIGHT;
    logic                          idle_q   = 1'b0;
    logic [imcr_pkg::DELAY_W-1:0]  still_q  = '0;

    blend_t queued_blends[$];

    function automatic blend_t ramp_tick(logic signed [imcr_pkg::VEL_W-1:0] vx,
                                         logic signed [imcr_pkg::VEL_W-1:0] vz,
                                         logic [imcr_pkg::DT_W-1:0] dt);
        longint                        sq;
        longint                        lim;
        logic [imcr_pkg::DELAY_W:0]    t;
        logic [32:0]                   step;
        logic [imcr_pkg::WEIGHT_W-1:0] goal;
        logic [imcr_pkg::WEIGHT_W-1:0] gap;
        blend_t                        r;
        sq  = longint'(vx) * longint'(vx) + longint'(vz) * longint'(vz);
        lim = longint'(thr_q) * longint'(thr_q);
        if (sq <= lim)
        begin
            // saturate the still timer instead of wrapping
            t = {1'b0, still_q} + dt;
            if (t > {1'b0, imcr_pkg::TIMER_MAX})
                t = {1'b0, imcr_pkg::TIMER_MAX};
            still_q = t[imcr_pkg::DELAY_W-1:0];
            if (still_q >= delay_q)
                idle_q = 1'b1;
        end
        else
        begin
            still_q = '0;
            idle_q  = 1'b0;
        end
        goal = idle_q ? '0 : imcr_pkg::FULL_WEIGHT;
        if (rate_q != 0)
        begin
            step = dt * rate_q;
            if (step > imcr_pkg::FULL_WEIGHT)
                step = imcr_pkg::FULL_WEIGHT;
            if (goal > weight_q)
            begin
                gap = goal - weight_q;
                weight_q = weight_q + ((step < gap) ? step[imcr_pkg::WEIGHT_W-1:0] : gap);
            end
            else
            begin
                gap = weight_q - goal;
                weight_q = weight_q - ((step < gap) ? step[imcr_pkg::WEIGHT_W-1:0] : gap);
            end
        end
        else
            weight_q = goal;
        r.weight = weight_q;
        r.idle   = idle_q;
        return r;
    endfunction

    always @(posedge clk)
    begin
        blend_t want;
        blend_t got;
        if (!rst_n)
        begin
            thr_q    = '0;
            delay_q  = '0;
            rate_q   = '0;
            weight_q = imcr_pkg::FULL_WEIGHT;
            idle_q   = 1'b0;
            still_q  = '0;
            queued_blends.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    imcr_pkg::REG_SPEED_THRESHOLD: thr_q   = cfg_data[imcr_pkg::THR_W-1:0];
                    imcr_pkg::REG_IDLE_DELAY:      delay_q = cfg_data[imcr_pkg::DELAY_W-1:0];
                    imcr_pkg::REG_FADE_RATE:       rate_q  = cfg_data[imcr_pkg::WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            // a result never leaves in the same cycle as its tick is taken, so compare before predicting
            if (m_tvalid && m_tready)
            begin
                got.weight = m_tdata[16:0];
                got.idle   = m_tdata[17];
                if (queued_blends.size() == 0)
                begin
                    $display("%0t: unexpected item, actual weight=%0d idle=%0b",
                             $realtime, got.weight, got.idle);
                    fails++;
                end
                else
                begin
                    want = queued_blends.pop_front();
                    if (got.weight !== want.weight)
                    begin
                        $display("%0t: move_weight mismatch, expected %0d actual %0d",
                                 $realtime, want.weight, got.weight);
                        fails++;
                    end
                    if (got.idle !== want.idle)
                    begin
                        $display("%0t: idle_target mismatch, expected %0b actual %0b",
                                 $realtime, want.idle, got.idle);
                        fails++;
                    end
                    if (m_tdata[23:18] !== 6'd0)
                    begin
                        $display("%0t: padding mismatch, expected 0 actual %0h",
                                 $realtime, m_tdata[23:18]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                queued_blends.push_back(ramp_tick(s_tdata[15:0], s_tdata[31:16],
                                                  s_tdata[47:32]));
        end
        pending = queued_blends.size();
    end

endmodule

>>> dv/testbench.sv
// Top of the crossfade ramp testbench: clock, reset, tick stimulus, config writes and verdict.
// Depends on imcr_pkg, idle_move_crossfade_ramp and imcr_blend_monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // vel_x[15:0], vel_z[31:16], delta_time[47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;    // move_weight[16:0], idle_target[17], zero[23:18]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    int fails;
    int pending;
    int cycle_count = 0;
    int ticks_sent  = 0;
    int send_idle   = 34;
    int recv_idle   = 83;
    int cur_thr     = 0;

    idle_move_crossfade_ramp u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    imcr_blend_monitor u_monitor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_tick(logic signed [15:0] vx, logic signed [15:0] vz, logic [15:0] dt);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dt, vz, vx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
        if (ticks_sent == 225)
        begin
            send_idle = 83;
            recv_idle = 34;
        end
        else if (ticks_sent == 450)
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        @(negedge clk);
    endtask

    // Drain the pipeline, then write all registers plus one unmapped index.
    task automatic set_regs(int thr, int delay, int rate);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= imcr_pkg::REG_SPEED_THRESHOLD;
        cfg_data  <= {8'($urandom), 16'(thr)};
        @(negedge clk);
        cfg_index <= imcr_pkg::REG_IDLE_DELAY;
        cfg_data  <= 24'(delay);
        @(negedge clk);
        cfg_index <= imcr_pkg::REG_FADE_RATE;
        cfg_data  <= {7'($urandom), 17'(rate)};
        @(negedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= 24'($urandom);
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_thr  = thr;
        @(negedge clk);
    endtask

    // Random ticks: still_pct of them aim under, on or just past the threshold, the rest are arbitrary.
    task automatic run_phase(int n, int still_pct, int dt_max, int top_dt_pct);
        int                 lim;
        int                 pick;
        logic signed [15:0] vx;
        logic signed [15:0] vz;
        logic [15:0]        dt;
        for (int i = 0; i < n; i++)
        begin
            lim = cur_thr / 2;
            if ($urandom_range(0, 99) < still_pct)
            begin
                if (cur_thr <= 32767 && $urandom_range(0, 7) == 0)
                begin
                    // land on the threshold or one past it
                    vx = 16'(cur_thr + $urandom_range(0, 1));
                    if ($urandom_range(0, 1))
                        vx = -vx;
                    vz = '0;
                    if ($urandom_range(0, 1))
                    begin
                        vz = vx;
                        vx = '0;
                    end
                end
                else
                begin
                    vx = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                    vz = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                end
            end
            else
            begin
                vx = 16'($urandom);
                vz = 16'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < top_dt_pct)
                dt = 16'hFFFF;
            else if (pick < top_dt_pct + 8)
                dt = '0;
            else
                dt = 16'($urandom_range(0, dt_max));
            send_tick(vx, vz, dt);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = imcr_pkg::REG_SPEED_THRESHOLD;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset config: zero threshold, zero delay, zero fade rate
        send_tick(16'sd1, 16'sd0, 16'd5);
        send_tick(16'sd0, 16'sd0, 16'd0);
        send_tick(-16'sd32768, -16'sd32768, 16'hFFFF);

        set_regs(100, 50, 1000);
        send_tick(16'sd100, 16'sd0, 16'd20);
        send_tick(-16'sd60, 16'sd80, 16'd30);
        send_tick(16'sd0, 16'sd0, 16'hFFFF);
        send_tick(16'sd61, 16'sd80, 16'd1);
        send_tick(16'sd0, -16'sd100, 16'd49);
        send_tick(16'sd0, 16'sd0, 16'd1);
        send_tick(16'sd32767, 16'sd32767, 16'd0);

        // Widest threshold and delay, fade rate above full scale
        set_regs(65535, int'(imcr_pkg::TIMER_MAX), 131071);
        send_tick(-16'sd32768, -16'sd32768, 16'hFFFF);
        send_tick(16'sd32767, -16'sd32768, 16'd1);

        set_regs(0, 0, 65536);
        send_tick(16'sd0, 16'sd0, 16'd1);
        send_tick(16'sd0, 16'sd1, 16'd1);
        send_tick(16'sd0, 16'sd0, 16'd0);

        set_regs($urandom_range(1, 3000), $urandom_range(0, 4000), $urandom_range(1, 3000));
        run_phase(100, 70, 300, 2);
        set_regs(0, 0, 0);
        run_phase(60, 50, 65535, 5);
        // every tick still with the longest step: drives the timer into saturation
        set_regs(65535, int'(imcr_pkg::TIMER_MAX), 131071);
        run_phase(270, 100, 65535, 100);
        set_regs($urandom_range(0, 65535), $urandom_range(0, 16777215),
                 $urandom_range(0, 131071));
        run_phase(100, 60, 65535, 5);
        set_regs($urandom_range(0, 65535), $urandom_range(0, 2000), $urandom_range(1, 16));
        run_phase(100, 75, 65535, 10);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/imcr_pkg.sv
sv/imcr_motion.sv
sv/imcr_ramp.sv
sv/idle_move_crossfade_ramp.sv
dv/imcr_blend_monitor.sv
dv/testbench.sv
